// ----- rtl/gzp_pkg.sv -----
// ----------------------------------------------------------------------------
// gzp_pkg
// shared types, constants and helpers of the gzip member header parser
// ----------------------------------------------------------------------------
package gzp_pkg;

  localparam int POSITION_BITS = 32;
  localparam int OFFSET_BITS   = 32;

  localparam logic [7:0] ID1_BYTE    = 8'h1f;
  localparam logic [7:0] ID2_BYTE    = 8'h8b;
  localparam logic [7:0] CM_DEFLATE  = 8'h08;
  localparam logic [7:0] FL_HCRC     = 8'h02;
  localparam logic [7:0] FL_EXTRA    = 8'h04;
  localparam logic [7:0] FL_NAME     = 8'h08;
  localparam logic [7:0] FL_COMMENT  = 8'h10;
  localparam logic [7:0] FL_RESERVED = 8'hE0;
  localparam int         FIXED_LEN   = 10;

  // register addresses, by word index
  localparam logic REG_CHECK_MAGIC = 1'b0;

  typedef enum logic [3:0] {
    PH_FIXED   = 4'd0,
    PH_XLEN_LO = 4'd1,
    PH_XLEN_HI = 4'd2,
    PH_EXTRA   = 4'd3,
    PH_NAME    = 4'd4,
    PH_COMMENT = 4'd5,
    PH_HCRC_LO = 4'd6,
    PH_HCRC_HI = 4'd7,
    PH_PAYLOAD = 4'd8,
    PH_ERROR   = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    CLS_HEADER = 2'd0,
    CLS_END    = 2'd1,
    CLS_PAY    = 2'd2,
    CLS_ERR    = 2'd3
  } byte_class_t;

  typedef struct packed {
    byte_class_t             byte_class;
    logic [7:0]              payload_byte;
    logic [OFFSET_BITS-1:0]  deflate_offset;
    logic                    end_of_buffer;
  } result_t;

  // first optional header part at or after 'from' that the flags ask for;
  // PH_PAYLOAD means the header is complete
  function automatic phase_t advance_from(input phase_t from, input logic [7:0] flags);
    phase_t nxt;
    nxt = PH_PAYLOAD;
    if (from <= PH_HCRC_LO && (flags & FL_HCRC) != 8'h00) nxt = PH_HCRC_LO;
    if (from <= PH_COMMENT && (flags & FL_COMMENT) != 8'h00) nxt = PH_COMMENT;
    if (from <= PH_NAME && (flags & FL_NAME) != 8'h00) nxt = PH_NAME;
    if (from <= PH_XLEN_LO && (flags & FL_EXTRA) != 8'h00) nxt = PH_XLEN_LO;
    return nxt;
  endfunction

endpackage

// ----- rtl/gzp_apb_regs.sv -----
// ----------------------------------------------------------------------------
// gzp_apb_regs
// register file behind the apb-style configuration port
// ----------------------------------------------------------------------------
module gzp_apb_regs
  import gzp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        check_magic
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_magic <= 1'b1;
    end else if (wr_en && paddr[2] == REG_CHECK_MAGIC) begin
      check_magic <= pwdata[0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_CHECK_MAGIC) begin
      prdata = {31'd0, check_magic};
    end
  end

endmodule

// ----- rtl/gzp_parser.sv -----
// ----------------------------------------------------------------------------
// gzp_parser
// header walk state and the per-byte classification step
// ----------------------------------------------------------------------------
module gzp_parser
  import gzp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       check_magic,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output result_t    result
);

  localparam logic [POSITION_BITS-1:0] PosMax   = '1;
  localparam logic [POSITION_BITS-1:0] PosOne   = POSITION_BITS'(1);
  localparam logic [POSITION_BITS-1:0] PosTwo   = POSITION_BITS'(2);
  localparam logic [POSITION_BITS-1:0] PosThree = POSITION_BITS'(3);
  localparam logic [POSITION_BITS-1:0] PosFixEnd = POSITION_BITS'(FIXED_LEN - 1);

  phase_t                   parse_phase, parse_phase_next;
  logic [7:0]               header_flags, header_flags_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [15:0]              extra_remaining, extra_remaining_next;
  logic [7:0]               extra_length_low, extra_length_low_next;

  logic                     done;
  logic                     bad;
  logic                     magic_bad;
  logic [15:0]              extra_len;
  logic [15:0]              extra_dec;
  logic [POSITION_BITS-1:0] pos_inc;
  phase_t                   adv;

  assign pos_inc   = byte_position + PosOne;
  assign extra_len = {data_byte, extra_length_low};
  assign extra_dec = extra_remaining - 16'd1;
  assign magic_bad = check_magic &&
                     ((byte_position == '0 && data_byte != ID1_BYTE) ||
                      (byte_position == PosOne && data_byte != ID2_BYTE) ||
                      (byte_position == PosTwo && data_byte != CM_DEFLATE));

  always_comb begin
    parse_phase_next      = parse_phase;
    header_flags_next     = header_flags;
    byte_position_next    = byte_position;
    extra_remaining_next  = extra_remaining;
    extra_length_low_next = extra_length_low;
    result.byte_class     = CLS_HEADER;
    result.payload_byte   = 8'd0;
    result.deflate_offset = '0;
    result.end_of_buffer  = last_byte;
    done = 1'b0;
    bad  = 1'b0;
    adv  = PH_PAYLOAD;

    if (parse_phase == PH_ERROR) begin
      result.byte_class = CLS_ERR;
    end else if (byte_position == PosMax) begin
      bad = 1'b1;
    end else begin
      byte_position_next = pos_inc;
      case (parse_phase)
        PH_FIXED: begin
          if (magic_bad) begin
            bad = 1'b1;
          end else if (byte_position == PosThree) begin
            header_flags_next = data_byte;
            if ((data_byte & FL_RESERVED) != 8'h00) bad = 1'b1;
          end else if (byte_position >= PosFixEnd) begin
            adv = advance_from(PH_XLEN_LO, header_flags);
            parse_phase_next = adv;
            done = (adv == PH_PAYLOAD);
          end
        end
        PH_XLEN_LO: begin
          extra_length_low_next = data_byte;
          parse_phase_next = PH_XLEN_HI;
        end
        PH_XLEN_HI: begin
          extra_remaining_next = extra_len;
          if (extra_len == 16'd0) begin
            adv = advance_from(PH_NAME, header_flags);
            parse_phase_next = adv;
            done = (adv == PH_PAYLOAD);
          end else begin
            parse_phase_next = PH_EXTRA;
          end
        end
        PH_EXTRA: begin
          extra_remaining_next = extra_dec;
          if (extra_dec == 16'd0) begin
            adv = advance_from(PH_NAME, header_flags);
            parse_phase_next = adv;
            done = (adv == PH_PAYLOAD);
          end
        end
        PH_NAME: begin
          if (data_byte == 8'd0) begin
            adv = advance_from(PH_COMMENT, header_flags);
            parse_phase_next = adv;
            done = (adv == PH_PAYLOAD);
          end
        end
        PH_COMMENT: begin
          if (data_byte == 8'd0) begin
            adv = advance_from(PH_HCRC_LO, header_flags);
            parse_phase_next = adv;
            done = (adv == PH_PAYLOAD);
          end
        end
        PH_HCRC_LO: begin
          parse_phase_next = PH_HCRC_HI;
        end
        PH_HCRC_HI: begin
          adv = advance_from(PH_PAYLOAD, header_flags);
          parse_phase_next = adv;
          done = 1'b1;
        end
        PH_PAYLOAD: begin
          result.byte_class   = CLS_PAY;
          result.payload_byte = data_byte;
        end
        default: begin
          bad = 1'b1;
        end
      endcase
      if (!bad && done) begin
        result.byte_class     = CLS_END;
        result.deflate_offset = OFFSET_BITS'(pos_inc);
      end
    end

    if (bad) begin
      parse_phase_next      = PH_ERROR;
      result.byte_class     = CLS_ERR;
      result.payload_byte   = 8'd0;
      result.deflate_offset = '0;
    end

    // a buffer may not end inside the header
    if (last_byte) begin
      if (result.byte_class == CLS_HEADER) result.byte_class = CLS_ERR;
      parse_phase_next      = PH_FIXED;
      header_flags_next     = 8'd0;
      byte_position_next    = '0;
      extra_remaining_next  = 16'd0;
      extra_length_low_next = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase      <= PH_FIXED;
      header_flags     <= 8'd0;
      byte_position    <= '0;
      extra_remaining  <= 16'd0;
      extra_length_low <= 8'd0;
    end else if (step) begin
      parse_phase      <= parse_phase_next;
      header_flags     <= header_flags_next;
      byte_position    <= byte_position_next;
      extra_remaining  <= extra_remaining_next;
      extra_length_low <= extra_length_low_next;
    end
  end

endmodule

// ----- rtl/gzip_member_header_parser.sv -----
// ----------------------------------------------------------------------------
// gzip_member_header_parser
// byte-wise gzip member header walker with payload pass-through
// ----------------------------------------------------------------------------
// Takes one byte of a gzip buffer per request, with last_byte on the final
// byte, and answers every byte with exactly one result: header byte, header
// end (deflate_offset then gives the header length, i.e. the index of the
// first DEFLATE byte), payload byte (passed through on payload_byte), or
// error. The ID bytes and method 8 are checked when check_magic is set
// (reset value 1, register at byte address 0); flag bits 0xE0 are always
// rejected. Extra field, file name, comment and header CRC are skipped as
// the flag byte asks. An error sticks until the final byte of the buffer,
// and every final byte returns the parser to the start of a new header.
// A buffer ending before the header is complete answers its final byte
// with error. One byte is accepted every clock cycle while the result side
// does not stall; each byte crosses one register for the incoming byte and
// one for the result, with the single state update of the parse step in
// between. Configuration may only be written while no byte is in flight.
// ----------------------------------------------------------------------------
module gzip_member_header_parser
  import gzp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // byte requests
  input  logic                   data_valid,
  output logic                   data_stall,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  // result requests
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [1:0]             byte_class,
  output logic [7:0]             payload_byte,
  output logic [OFFSET_BITS-1:0] deflate_offset,
  output logic                   end_of_buffer,
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic       check_magic;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // result register
  result_t    step_result;
  result_t    out_q;
  logic       out_valid;

  logic       out_load;
  logic       step;

  gzp_apb_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .check_magic (check_magic)
  );

  // result register can take a new value when empty or being drained
  assign out_load   = !out_valid || !result_stall;
  assign step       = in_valid && out_load;
  // input register holds while its byte cannot move on
  assign data_stall = in_valid && !out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!data_stall) begin
      in_valid <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && !data_stall) begin
      in_byte <= data_byte;
      in_last <= last_byte;
    end
  end

  gzp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .check_magic (check_magic),
    .step        (step),
    .data_byte   (in_byte),
    .last_byte   (in_last),
    .result      (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_q <= step_result;
    end
  end

  assign result_valid   = out_valid;
  assign byte_class     = out_q.byte_class;
  assign payload_byte   = out_q.payload_byte;
  assign deflate_offset = out_q.deflate_offset;
  assign end_of_buffer  = out_q.end_of_buffer;

  // header end points past the fixed header; checked here as a nonzero offset
  a_offset_nonzero : assert property (@(posedge clk) disable iff (rst)
    (result_valid && byte_class == CLS_END) |-> (deflate_offset != '0))
    else $error("header end with zero offset");

  // payload data only shows on payload results
  a_payload_clean : assert property (@(posedge clk) disable iff (rst)
    (result_valid && byte_class != CLS_PAY) |-> (payload_byte == 8'd0))
    else $error("payload byte set on non-payload result");

  // a buffer never ends on a plain header byte
  a_no_open_end : assert property (@(posedge clk) disable iff (rst)
    (result_valid && end_of_buffer) |-> (byte_class != CLS_HEADER))
    else $error("final byte classified as header byte");

  // offset only carried on header end
  a_offset_only_end : assert property (@(posedge clk) disable iff (rst)
    (result_valid && byte_class != CLS_END) |-> (deflate_offset == '0))
    else $error("offset on non header-end result");

endmodule

// ----- tb/sv/tb_gzip_member_header_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gzip_member_header_parser
// self-checking testbench for the byte-wise gzip member header parser
// ----------------------------------------------------------------------------
// Feeds gzip buffers one byte per request and predicts the class of every
// byte with an in-bench copy of the header walk. Covers directed corner
// cases (full header with every optional part, bad ID, reserved flag bits,
// truncated header), then random buffers, mostly well-formed with random
// content and some corrupted, truncated or pure noise, under both settings
// of check_magic. The sender idles in random bursts, the receiver stalls on
// its own pattern, and one long receiver hold backs the block up.
// ----------------------------------------------------------------------------
module tb_gzip_member_header_parser;
  import gzp_pkg::*;

  localparam int         HOLD_CYCLES      = 400;
  localparam int         DRAIN_LIMIT      = 5000;
  localparam int         MAX_PRINTS       = 40;
  localparam longint     TIMEOUT_NS       = 4_000_000;
  localparam logic [2:0] CHECK_MAGIC_ADDR = {REG_CHECK_MAGIC, 2'b00};

  // dut signals; the inputs are known from time zero
  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   data_valid   = 1'b0;
  logic                   data_stall;
  logic [7:0]             data_byte    = 8'h00;
  logic                   last_byte    = 1'b0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic [1:0]             byte_class;
  logic [7:0]             payload_byte;
  logic [OFFSET_BITS-1:0] deflate_offset;
  logic                   end_of_buffer;
  logic                   psel         = 1'b0;
  logic                   penable      = 1'b0;
  logic                   pwrite       = 1'b0;
  logic [2:0]             paddr        = 3'd0;
  logic [31:0]            pwdata       = 32'd0;
  logic [31:0]            prdata;
  logic                   pready;

  // predicted results, oldest first
  result_t expected_tags[$];
  int      fail_count = 0;

  // predictor copy of the parser state and register
  phase_t                   hdr_phase;
  logic [7:0]               hdr_flags;
  logic [POSITION_BITS-1:0] byte_count;
  logic [15:0]              extra_left;
  logic [7:0]               xlen_low;
  logic                     magic_on;

  // sender burst control
  int burst_left     = 0;
  bit sender_gaps_on = 1'b1;

  // receiver stall control; hold_asks is bumped by a test to ask for a hold
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int span_left = 0;
  int stall_pct = 0;

  // bytes of the buffer about to be sent
  logic [7:0] member_bytes[$];

  gzip_member_header_parser uut (
    .clk            (clk),
    .rst            (rst),
    .data_valid     (data_valid),
    .data_stall     (data_stall),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .byte_class     (byte_class),
    .payload_byte   (payload_byte),
    .deflate_offset (deflate_offset),
    .end_of_buffer  (end_of_buffer),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #2 clk = ~clk;

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------

  // back to the start of a new header; the register is kept
  function automatic void clear_parse();
    hdr_phase  = PH_FIXED;
    hdr_flags  = 8'h00;
    byte_count = '0;
    extra_left = 16'h0000;
    xlen_low   = 8'h00;
  endfunction

  // pick the next optional header part at or after 'start'; returns 1 when
  // nothing is left and the payload begins
  function automatic logic enter_section(input phase_t start);
    if (start <= PH_XLEN_LO && (hdr_flags & FL_EXTRA) != 8'h00) hdr_phase = PH_XLEN_LO;
    else if (start <= PH_NAME && (hdr_flags & FL_NAME) != 8'h00) hdr_phase = PH_NAME;
    else if (start <= PH_COMMENT && (hdr_flags & FL_COMMENT) != 8'h00) hdr_phase = PH_COMMENT;
    else if (start <= PH_HCRC_LO && (hdr_flags & FL_HCRC) != 8'h00) hdr_phase = PH_HCRC_LO;
    else hdr_phase = PH_PAYLOAD;
    return hdr_phase == PH_PAYLOAD;
  endfunction

  // one byte in, one tagged result out
  function automatic result_t classify_byte(input logic [7:0] b, input logic fin);
    result_t                  r;
    logic [POSITION_BITS-1:0] idx;
    logic                     complete;
    logic                     broken;
    r          = '0;
    r.byte_class = CLS_HEADER;
    complete   = 1'b0;
    broken     = 1'b0;
    if (hdr_phase == PH_ERROR) begin
      r.byte_class = CLS_ERR;
    end else if (&byte_count) begin
      // position counter would wrap
      broken = 1'b1;
    end else begin
      idx        = byte_count;
      byte_count = byte_count + 1'b1;
      case (hdr_phase)
        PH_FIXED: begin
          if (magic_on && ((idx == 0 && b != ID1_BYTE) || (idx == 1 && b != ID2_BYTE) ||
                           (idx == 2 && b != CM_DEFLATE))) begin
            broken = 1'b1;
          end else if (idx == 3) begin
            hdr_flags = b;
            if ((b & FL_RESERVED) != 8'h00) broken = 1'b1;
          end else if (idx >= FIXED_LEN - 1) begin
            complete = enter_section(PH_XLEN_LO);
          end
        end
        PH_XLEN_LO: begin
          xlen_low  = b;
          hdr_phase = PH_XLEN_HI;
        end
        PH_XLEN_HI: begin
          extra_left = {b, xlen_low};
          if (extra_left == 16'h0000) complete = enter_section(PH_NAME);
          else hdr_phase = PH_EXTRA;
        end
        PH_EXTRA: begin
          extra_left = extra_left - 1'b1;
          if (extra_left == 16'h0000) complete = enter_section(PH_NAME);
        end
        PH_NAME: begin
          if (b == 8'h00) complete = enter_section(PH_COMMENT);
        end
        PH_COMMENT: begin
          if (b == 8'h00) complete = enter_section(PH_HCRC_LO);
        end
        PH_HCRC_LO: begin
          hdr_phase = PH_HCRC_HI;
        end
        PH_HCRC_HI: begin
          complete = enter_section(PH_PAYLOAD);
        end
        PH_PAYLOAD: begin
          r.byte_class   = CLS_PAY;
          r.payload_byte = b;
        end
        default: begin
          broken = 1'b1;
        end
      endcase
      if (!broken && complete) begin
        r.byte_class     = CLS_END;
        r.deflate_offset = OFFSET_BITS'(idx + 1'b1);
      end
    end
    if (broken) begin
      hdr_phase        = PH_ERROR;
      r.byte_class     = CLS_ERR;
      r.payload_byte   = 8'h00;
      r.deflate_offset = '0;
    end
    // a buffer that ends inside the header is an error
    if (fin) begin
      if (r.byte_class == CLS_HEADER) r.byte_class = CLS_ERR;
      clear_parse();
    end
    r.end_of_buffer = fin;
    return r;
  endfunction

  // predict at every accepted byte request
  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      magic_on = 1'b1;
    end else if (data_valid && !data_stall) begin
      expected_tags.push_back(classify_byte(data_byte, last_byte));
    end
  end

  // ------------------------------------------------------------------------
  // checking
  // ------------------------------------------------------------------------

  // one line per mismatch, printing stops after a while but counting goes on
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < MAX_PRINTS)
      $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  // compare every accepted result request with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_tags.size() == 0) begin
        report_mismatch("result with nothing pending", byte_class, 0);
      end else begin
        want = expected_tags.pop_front();
        if (byte_class !== want.byte_class)
          report_mismatch("byte_class", byte_class, want.byte_class);
        if (payload_byte !== want.payload_byte)
          report_mismatch("payload_byte", payload_byte, want.payload_byte);
        if (deflate_offset !== want.deflate_offset)
          report_mismatch("deflate_offset", deflate_offset, want.deflate_offset);
        if (end_of_buffer !== want.end_of_buffer)
          report_mismatch("end_of_buffer", end_of_buffer, want.end_of_buffer);
      end
    end
  end

  // ------------------------------------------------------------------------
  // receiver: stall pattern with changing density, plus a long hold on demand
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES - 1;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      // a new stall density every so often, zero for stretches of full rate
      if (span_left == 0) begin
        case ($urandom_range(0, 4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 25;
          3:       stall_pct = 50;
          default: stall_pct = 80;
        endcase
        span_left = $urandom_range(16, 96);
      end else begin
        span_left--;
      end
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ------------------------------------------------------------------------
  // sender and config helpers; all start and end just after a rising edge
  // ------------------------------------------------------------------------

  // offer one byte request, hold it until taken, then maybe pause the sender
  task automatic send_byte(input logic [7:0] b, input logic fin);
    data_valid <= 1'b1;
    data_byte  <= b;
    last_byte  <= fin;
    @(posedge clk);
    while (data_stall) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else if (sender_gaps_on) begin
      data_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // now and then a long burst with no gaps at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(0, 30);
    end
  endtask

  // send the staged buffer, marking its final byte
  task automatic send_member();
    foreach (member_bytes[i]) send_byte(member_bytes[i], i == member_bytes.size() - 1);
  endtask

  // stop offering and let every predicted result come back
  task automatic wait_idle();
    int waited;
    waited = 0;
    data_valid <= 1'b0;
    while (expected_tags.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_tags.size() != 0) begin
      report_mismatch("results never delivered", expected_tags.size(), 0);
      expected_tags.delete();
    end
    // a result follows its byte through the input and result registers, leave some margin
    repeat (4) @(posedge clk);
  endtask

  // one apb transfer: setup cycle then access cycle, then the bus goes idle
  task automatic apb_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CHECK_MAGIC_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // build a random buffer; well-formed ones may still get a corrupted id,
  // reserved flag bits or a truncated end
  task automatic build_member(input bit well_formed);
    logic [7:0]  fl;
    logic [15:0] xlen;
    int          k;
    bit          cut_in_extra;
    member_bytes.delete();
    cut_in_extra = 1'b0;
    if (!well_formed) begin
      repeat ($urandom_range(1, 14)) member_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    // id and method, random garbage allowed when the check is off
    if (!magic_on && $urandom_range(0, 1) == 0) begin
      repeat (3) member_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      member_bytes.push_back(ID1_BYTE);
      member_bytes.push_back(ID2_BYTE);
      member_bytes.push_back(CM_DEFLATE);
    end
    if ($urandom_range(0, 15) == 0) begin
      k = $urandom_range(0, 2);
      member_bytes[k] = member_bytes[k] ^ (8'h01 << $urandom_range(0, 7));
    end
    fl = 8'($urandom_range(0, 31));
    if ($urandom_range(0, 15) == 0) fl[7:5] = 3'($urandom_range(1, 7));
    member_bytes.push_back(fl);
    // mtime, xfl, os
    repeat (6) member_bytes.push_back(8'($urandom_range(0, 255)));
    if ((fl & FL_EXTRA) != 8'h00) begin
      case ($urandom_range(0, 63))
        0, 1:    xlen = 16'h0000;
        2:       xlen = 16'($urandom_range(0, 65535));
        3:       xlen = 16'($urandom_range(256, 300));
        default: xlen = 16'($urandom_range(1, 6));
      endcase
      member_bytes.push_back(xlen[7:0]);
      member_bytes.push_back(xlen[15:8]);
      // huge extra fields are cut short, the buffer ends inside them
      if (xlen > 300) begin
        cut_in_extra = 1'b1;
        k = $urandom_range(1, 300);
      end else begin
        k = xlen;
      end
      repeat (k) member_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if (!cut_in_extra) begin
      if ((fl & FL_NAME) != 8'h00) begin
        repeat ($urandom_range(0, 8)) member_bytes.push_back(8'($urandom_range(1, 255)));
        member_bytes.push_back(8'h00);
      end
      if ((fl & FL_COMMENT) != 8'h00) begin
        repeat ($urandom_range(0, 8)) member_bytes.push_back(8'($urandom_range(1, 255)));
        member_bytes.push_back(8'h00);
      end
      if ((fl & FL_HCRC) != 8'h00) begin
        repeat (2) member_bytes.push_back(8'($urandom_range(0, 255)));
      end
      // empty payload leaves the header end on the final byte
      repeat ($urandom_range(0, 24)) member_bytes.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0 && member_bytes.size() > 1)
        member_bytes = member_bytes[0:$urandom_range(0, member_bytes.size() - 2)];
    end
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // register comes out of reset with the id check on
  task automatic test_register_reset();
    logic [31:0] rd;
    apb_access(1'b0, 32'd0, rd);
    if (rd[0] !== 1'b1) report_mismatch("check_magic after reset", rd[0], 1);
  endtask

  // write check_magic while idle, read it back, track it in the predictor
  task automatic test_check_magic_setting(input logic value);
    logic [31:0] rd;
    wait_idle();
    apb_access(1'b1, {31'd0, value}, rd);
    magic_on = value;
    apb_access(1'b0, 32'd0, rd);
    if (rd[0] !== value) report_mismatch("check_magic readback", rd[0], value);
  endtask

  task automatic test_directed_cases();
    // every optional part plus the text bit, header ends on the final byte
    member_bytes = '{ID1_BYTE, ID2_BYTE, CM_DEFLATE, 8'h1f,
                     8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff,
                     8'h01, 8'h00, 8'hff, 8'h00, 8'h00, 8'hab, 8'hcd};
    send_member();
    // bad first id byte, error sticks to the end of the buffer
    member_bytes = '{8'h1e, ID2_BYTE, CM_DEFLATE};
    send_member();
    // reserved flag bits with text bit set
    member_bytes = '{ID1_BYTE, ID2_BYTE, CM_DEFLATE, 8'he1};
    send_member();
    // buffer ends inside the fixed header
    member_bytes = '{ID1_BYTE, ID2_BYTE};
    send_member();
  endtask

  task automatic test_random_buffers(input int target);
    int sent;
    sent = 0;
    while (sent < target) begin
      build_member($urandom_range(0, 9) != 0);
      send_member();
      sent += member_bytes.size();
    end
  endtask

  // receiver holds off while the sender keeps offering at full rate
  task automatic test_receiver_hold();
    int sent;
    sent = 0;
    sender_gaps_on = 1'b0;
    hold_asks++;
    while (sent < 120) begin
      build_member(1'b1);
      send_member();
      sent += member_bytes.size();
    end
    sender_gaps_on = 1'b1;
  endtask

  // ------------------------------------------------------------------------
  // run
  // ------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_reset();
    test_directed_cases();
    test_random_buffers(500);
    test_check_magic_setting(1'b0);
    test_random_buffers(400);
    test_receiver_hold();
    test_check_magic_setting(1'b1);
    test_random_buffers(300);
    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule
